[src/mcsl_pkg.sv]
// Shared types, widths and constants of the motor command slew limiter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mcsl_pkg;

    // Field widths fixed by the command formats.
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned PULSE_W = 12;
    localparam int unsigned FRAC_W  = 10;
    localparam int unsigned VEL_W   = 30;
    localparam int unsigned AMP_W   = 27;
    localparam int unsigned LIM_W   = 22;
    localparam int unsigned PHASE_W = 23;
    localparam int unsigned RATE_W  = 17;

    // Pulse window mapped onto a fraction of 0..1000.
    localparam int unsigned PULSE_LO = 1000;
    localparam int unsigned PULSE_HI = 2000;

    // Quotient and remainder widths of the register values divided by 1000.
    localparam int unsigned VEL_Q_W = 21;
    localparam int unsigned AMP_Q_W = 18;
    localparam int unsigned PH_Q_W  = 14;
    localparam int unsigned REM_W   = 10;

    // Time step limits; steps are held at the width of the largest allowed dt.
    localparam int unsigned DT_MAX_US_DEFAULT = 10000;
    localparam int unsigned DT_MAX_US_LIMIT   = 1000000;
    localparam int unsigned DT_W_MAX          = $clog2(DT_MAX_US_LIMIT + 1);
    localparam int unsigned STEP_W            = RATE_W + DT_W_MAX;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 30;

    // Queue between the front and the back part.
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register values after reset.
    localparam logic [VEL_W-1:0]  VEL_MAX_RESET  = 30'd478600000;
    localparam logic [AMP_W-1:0]  AMP_MAX_RESET  = 27'd40000000;
    localparam logic [LIM_W-1:0]  LIM_RESET      = 22'd3141593;
    localparam logic [RATE_W-1:0] VEL_RISE_RESET = 17'd200;
    localparam logic [RATE_W-1:0] VEL_FALL_RESET = 17'd120;
    localparam logic [RATE_W-1:0] AMP_RISE_RESET = 17'd60;
    localparam logic [RATE_W-1:0] AMP_FALL_RESET = 17'd90;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VELOCITY_MAX        = 3'd0,
        CFG_AMPLITUDE_MAX       = 3'd1,
        CFG_PHASE_LIMIT         = 3'd2,
        CFG_VELOCITY_RISE_RATE  = 3'd3,
        CFG_VELOCITY_FALL_RATE  = 3'd4,
        CFG_AMPLITUDE_RISE_RATE = 3'd5,
        CFG_AMPLITUDE_FALL_RATE = 3'd6
    } cfg_reg_t;

    typedef logic [STEP_W-1:0] step_t;

    // A register value split as q * 1000 + r.
    typedef struct packed {
        logic [VEL_Q_W-1:0] q;
        logic [REM_W-1:0]   r;
    } div_t;

    // Register bank as the front part sees it.
    typedef struct packed {
        logic [VEL_Q_W-1:0] vel_q;
        logic [REM_W-1:0]   vel_r;
        logic [AMP_Q_W-1:0] amp_q;
        logic [REM_W-1:0]   amp_r;
        logic [PH_Q_W-1:0]  ph_q;
        logic [REM_W-1:0]   ph_r;
        logic [LIM_W-1:0]   lim;
        logic [RATE_W-1:0]  vel_rise;
        logic [RATE_W-1:0]  vel_fall;
        logic [RATE_W-1:0]  amp_rise;
        logic [RATE_W-1:0]  amp_fall;
    } cfg_t;

    // One classified item waiting for the slew stage.
    typedef struct packed {
        logic                      is_init;
        logic [VEL_W-1:0]          vel_target;
        logic [AMP_W-1:0]          amp_target;
        logic signed [PHASE_W-1:0] phase;
        step_t                     vel_rise_step;
        step_t                     vel_fall_step;
        step_t                     amp_rise_step;
        step_t                     amp_fall_step;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } q_wr_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

[src/mcsl_channels.sv]
// Handshake channels of the slew limiter: tick items in, result items out,
// and the configuration write channel. Depends on mcsl_pkg.
`default_nettype none

interface mcsl_tick_if;
    import mcsl_pkg::*;

    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  time_us;
    logic               armed;
    logic [PULSE_W-1:0] throttle_pulse;
    logic [PULSE_W-1:0] aux1_pulse;
    logic [PULSE_W-1:0] aux2_pulse;

    modport source (
        output valid, time_us, armed, throttle_pulse, aux1_pulse, aux2_pulse,
        input  ready
    );
    modport sink (
        input  valid, time_us, armed, throttle_pulse, aux1_pulse, aux2_pulse,
        output ready
    );
endinterface

interface mcsl_result_if;
    import mcsl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      is_init;
    logic [VEL_W-1:0]          velocity_cmd;
    logic [AMP_W-1:0]          amplitude_cmd;
    logic signed [PHASE_W-1:0] phase_cmd;

    modport source (
        output valid, is_init, velocity_cmd, amplitude_cmd, phase_cmd,
        input  ready
    );
    modport sink (
        input  valid, is_init, velocity_cmd, amplitude_cmd, phase_cmd,
        output ready
    );
endinterface

interface mcsl_cfg_if;
    import mcsl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

[src/mcsl_cfg.sv]
// Configuration register bank; scaling limits are held pre-divided by 1000.
// Depends on mcsl_pkg and mcsl_channels.
`default_nettype none

module mcsl_cfg (
    input  logic              clk,
    input  logic              rst_n,
    mcsl_cfg_if.sink          cfg,
    output mcsl_pkg::cfg_t    regs
);
    import mcsl_pkg::*;

    // floor(v / 1000) as floor((v >> 3) * ceil(2^34 / 125) / 2^34), exact for 30 bits.
    localparam int unsigned DIV_N_W     = VEL_W - 3;
    localparam int unsigned DIV_PROD_W  = 55;
    localparam int unsigned RECIP_SHIFT = 34;
    localparam logic [DIV_PROD_W-1:0] RECIP_125 = 55'd137438954;

    function automatic div_t div1000(input logic [VEL_W-1:0] v);
        logic [DIV_PROD_W-1:0] prod;
        logic [VEL_Q_W-1:0]    q;
        logic [VEL_W:0]        qk;
        div_t                  d;
        prod = DIV_PROD_W'(v[VEL_W-1:3]) * RECIP_125;
        q    = prod[RECIP_SHIFT+VEL_Q_W-1:RECIP_SHIFT];
        qk   = (VEL_W+1)'(q) * (VEL_W+1)'(PULSE_HI - PULSE_LO);
        d.q  = q;
        d.r  = REM_W'(v - qk[VEL_W-1:0]);
        return d;
    endfunction

    localparam div_t VEL_DIV_RESET = div1000(VEL_MAX_RESET);
    localparam div_t AMP_DIV_RESET = div1000(VEL_W'(AMP_MAX_RESET));
    localparam div_t PH_DIV_RESET  = div1000(VEL_W'({LIM_RESET, 1'b0}));

    localparam cfg_t CFG_RESET = '{
        vel_q:    VEL_DIV_RESET.q,
        vel_r:    VEL_DIV_RESET.r,
        amp_q:    AMP_DIV_RESET.q[AMP_Q_W-1:0],
        amp_r:    AMP_DIV_RESET.r,
        ph_q:     PH_DIV_RESET.q[PH_Q_W-1:0],
        ph_r:     PH_DIV_RESET.r,
        lim:      LIM_RESET,
        vel_rise: VEL_RISE_RESET,
        vel_fall: VEL_FALL_RESET,
        amp_rise: AMP_RISE_RESET,
        amp_fall: AMP_FALL_RESET
    };

    cfg_t             regs_reg;
    cfg_t             regs_next;
    logic [VEL_W-1:0] div_in;
    div_t             div_out;

    // Writes are always taken.
    assign cfg.ready = 1'b1;

    // One shared divider serves the three scaling registers.
    always_comb
    begin
        case (cfg.index)
            CFG_AMPLITUDE_MAX: div_in = VEL_W'(cfg.data[AMP_W-1:0]);
            CFG_PHASE_LIMIT:   div_in = VEL_W'({cfg.data[LIM_W-1:0], 1'b0});
            default:           div_in = cfg.data[VEL_W-1:0];
        endcase
    end

    assign div_out = div1000(div_in);

    // Register write decode; an index beyond the list changes nothing.
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_VELOCITY_MAX:
                begin
                    regs_next.vel_q = div_out.q;
                    regs_next.vel_r = div_out.r;
                end
                CFG_AMPLITUDE_MAX:
                begin
                    regs_next.amp_q = div_out.q[AMP_Q_W-1:0];
                    regs_next.amp_r = div_out.r;
                end
                CFG_PHASE_LIMIT:
                begin
                    regs_next.ph_q = div_out.q[PH_Q_W-1:0];
                    regs_next.ph_r = div_out.r;
                    regs_next.lim  = cfg.data[LIM_W-1:0];
                end
                CFG_VELOCITY_RISE_RATE:  regs_next.vel_rise = cfg.data[RATE_W-1:0];
                CFG_VELOCITY_FALL_RATE:  regs_next.vel_fall = cfg.data[RATE_W-1:0];
                CFG_AMPLITUDE_RISE_RATE: regs_next.amp_rise = cfg.data[RATE_W-1:0];
                CFG_AMPLITUDE_FALL_RATE: regs_next.amp_fall = cfg.data[RATE_W-1:0];
                default:                 regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= CFG_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

[src/mcsl_front.sv]
// Front part: accepts tick items, derives dt, maps pulses to targets and
// precomputes the slew steps. Depends on mcsl_pkg and mcsl_channels.
`default_nettype none

module mcsl_front #(
    parameter int unsigned DT_MAX_US = mcsl_pkg::DT_MAX_US_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    mcsl_tick_if.sink         tick,
    input  mcsl_pkg::cfg_t    regs,
    input  logic              pop,
    output mcsl_pkg::q_wr_t   wr
);
    import mcsl_pkg::*;

    localparam int unsigned DT_W   = $clog2(DT_MAX_US + 1);
    localparam int unsigned PROD_W = RATE_W + DT_W;
    localparam int unsigned VA_W   = VEL_Q_W + FRAC_W;
    localparam int unsigned AA_W   = AMP_Q_W + FRAC_W;
    localparam int unsigned PA_W   = PH_Q_W + FRAC_W;
    localparam int unsigned B_W    = REM_W + FRAC_W;
    localparam int unsigned BN_W   = B_W - 3;
    localparam int unsigned BP_W   = 35;
    localparam int unsigned BSHIFT = 24;
    localparam logic [BP_W-1:0] RECIP_125 = 35'd134218;

    // Clamp a pulse to the window and return its offset 0..1000.
    function automatic logic [FRAC_W-1:0] pulse_frac(input logic [PULSE_W-1:0] p);
        logic [PULSE_W-1:0] c;
        c = p;
        if (p < PULSE_W'(PULSE_LO))
        begin
            c = PULSE_W'(PULSE_LO);
        end
        if (p > PULSE_W'(PULSE_HI))
        begin
            c = PULSE_W'(PULSE_HI);
        end
        return FRAC_W'(c - PULSE_W'(PULSE_LO));
    endfunction

    // floor(b / 1000) for b below 10^6, by reciprocal of 125 after a shift.
    function automatic logic [FRAC_W-1:0] rem_div1000(input logic [B_W-1:0] b);
        logic [BP_W-1:0] prod;
        prod = BP_W'(b[B_W-1:3]) * RECIP_125;
        return prod[BSHIFT+FRAC_W-1:BSHIFT];
    endfunction

    logic              accept;
    logic [QCNT_W-1:0] credit_reg;
    logic [QCNT_W-1:0] credit_next;
    logic              started_reg;
    logic [TIME_W-1:0] previous_time_reg;
    logic [TIME_W-1:0] diff;
    logic [DT_W-1:0]   dt_next;

    // First stage registers.
    logic              s0_valid_reg;
    logic              s0_init_reg;
    logic              s0_armed_reg;
    logic [DT_W-1:0]   s0_dt_reg;
    logic [FRAC_W-1:0] s0_tv_reg;
    logic [FRAC_W-1:0] s0_ta_reg;
    logic [FRAC_W-1:0] s0_tp_reg;

    // Second stage products.
    logic [VA_W-1:0]   vel_a_next;
    logic [B_W-1:0]    vel_b_next;
    logic [AA_W-1:0]   amp_a_next;
    logic [B_W-1:0]    amp_b_next;
    logic [PA_W-1:0]   ph_a_next;
    logic [B_W-1:0]    ph_b_next;
    logic [PROD_W-1:0] vel_rise_next;
    logic [PROD_W-1:0] vel_fall_next;
    logic [PROD_W-1:0] amp_rise_next;
    logic [PROD_W-1:0] amp_fall_next;

    logic               s1_valid_reg;
    logic               s1_init_reg;
    logic               s1_armed_reg;
    logic [VEL_W-1:0]   s1_vel_a_reg;
    logic [B_W-1:0]     s1_vel_b_reg;
    logic [AMP_W-1:0]   s1_amp_a_reg;
    logic [B_W-1:0]     s1_amp_b_reg;
    logic [PHASE_W-1:0] s1_ph_a_reg;
    logic [B_W-1:0]     s1_ph_b_reg;
    step_t              s1_vel_rise_reg;
    step_t              s1_vel_fall_reg;
    step_t              s1_amp_rise_reg;
    step_t              s1_amp_fall_reg;

    logic [VEL_W-1:0]   vel_target;
    logic [AMP_W-1:0]   amp_target;
    logic [PHASE_W:0]   phase_sum;

    // Credits cover every item between the input and the head of the queue.
    assign tick.ready  = credit_reg < QCNT_W'(QUEUE_DEPTH);
    assign accept      = tick.valid && tick.ready;
    assign credit_next = credit_reg + QCNT_W'(accept) - QCNT_W'(pop);

    // Wrapped time difference: negative gives zero, large gaps saturate.
    assign diff = tick.time_us - previous_time_reg;

    always_comb
    begin
        if (diff[TIME_W-1])
        begin
            dt_next = '0;
        end
        else if (diff > TIME_W'(DT_MAX_US))
        begin
            dt_next = DT_W'(DT_MAX_US);
        end
        else
        begin
            dt_next = diff[DT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg        <= '0;
            started_reg       <= 1'b0;
            previous_time_reg <= '0;
            s0_valid_reg      <= 1'b0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
            if (accept)
            begin
                started_reg       <= 1'b1;
                previous_time_reg <= tick.time_us;
            end
        end
    end

    // Classify the item as it is accepted.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_init_reg  <= !started_reg;
            s0_armed_reg <= tick.armed;
            s0_dt_reg    <= dt_next;
            s0_tv_reg    <= pulse_frac(tick.throttle_pulse);
            s0_ta_reg    <= pulse_frac(tick.aux1_pulse);
            s0_tp_reg    <= pulse_frac(tick.aux2_pulse);
        end
    end

    // Scaling products (register value split as q * 1000 + r) and slew steps.
    assign vel_a_next    = VA_W'(regs.vel_q) * VA_W'(s0_tv_reg);
    assign vel_b_next    = B_W'(regs.vel_r) * B_W'(s0_tv_reg);
    assign amp_a_next    = AA_W'(regs.amp_q) * AA_W'(s0_ta_reg);
    assign amp_b_next    = B_W'(regs.amp_r) * B_W'(s0_ta_reg);
    assign ph_a_next     = PA_W'(regs.ph_q) * PA_W'(s0_tp_reg);
    assign ph_b_next     = B_W'(regs.ph_r) * B_W'(s0_tp_reg);
    assign vel_rise_next = PROD_W'(regs.vel_rise) * PROD_W'(s0_dt_reg);
    assign vel_fall_next = PROD_W'(regs.vel_fall) * PROD_W'(s0_dt_reg);
    assign amp_rise_next = PROD_W'(regs.amp_rise) * PROD_W'(s0_dt_reg);
    assign amp_fall_next = PROD_W'(regs.amp_fall) * PROD_W'(s0_dt_reg);

    always_ff @(posedge clk)
    begin
        s1_init_reg     <= s0_init_reg;
        s1_armed_reg    <= s0_armed_reg;
        s1_vel_a_reg    <= vel_a_next[VEL_W-1:0];
        s1_vel_b_reg    <= vel_b_next;
        s1_amp_a_reg    <= amp_a_next[AMP_W-1:0];
        s1_amp_b_reg    <= amp_b_next;
        s1_ph_a_reg     <= ph_a_next[PHASE_W-1:0];
        s1_ph_b_reg     <= ph_b_next;
        s1_vel_rise_reg <= step_t'(vel_rise_next);
        s1_vel_fall_reg <= step_t'(vel_fall_next);
        s1_amp_rise_reg <= step_t'(amp_rise_next);
        s1_amp_fall_reg <= step_t'(amp_fall_next);
    end

    // Finish the targets; the phase offset wraps into two's complement.
    assign vel_target = s1_vel_a_reg + VEL_W'(rem_div1000(s1_vel_b_reg));
    assign amp_target = s1_amp_a_reg + AMP_W'(rem_div1000(s1_amp_b_reg));
    assign phase_sum  = (PHASE_W+1)'(s1_ph_a_reg)
                      + (PHASE_W+1)'(rem_div1000(s1_ph_b_reg))
                      - (PHASE_W+1)'(regs.lim);

    // Disarmed and init items carry zero targets.
    always_comb
    begin
        wr.push                = s1_valid_reg;
        wr.entry.is_init       = s1_init_reg;
        wr.entry.vel_rise_step = s1_vel_rise_reg;
        wr.entry.vel_fall_step = s1_vel_fall_reg;
        wr.entry.amp_rise_step = s1_amp_rise_reg;
        wr.entry.amp_fall_step = s1_amp_fall_reg;
        if (s1_armed_reg && !s1_init_reg)
        begin
            wr.entry.vel_target = vel_target;
            wr.entry.amp_target = amp_target;
            wr.entry.phase      = phase_sum[PHASE_W-1:0];
        end
        else
        begin
            wr.entry.vel_target = '0;
            wr.entry.amp_target = '0;
            wr.entry.phase      = '0;
        end
    end

endmodule

`default_nettype wire

[src/mcsl_queue.sv]
// Short queue of classified items between the front and the back part.
// Depends on mcsl_pkg.
`default_nettype none

module mcsl_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  mcsl_pkg::q_wr_t   wr,
    input  logic              pop,
    output mcsl_pkg::entry_t  head,
    output mcsl_pkg::q_stat_t stat
);
    import mcsl_pkg::*;

    entry_t            slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign count_next = count_reg + QCNT_W'(wr.push) - QCNT_W'(pop);

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            slots_reg[wr_ptr_reg] <= wr.entry;
        end
    end

    assign head       = slots_reg[rd_ptr_reg];
    assign stat.empty = count_reg == '0;
    assign stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);

endmodule

`default_nettype wire

[src/mcsl_back.sv]
// Back part: slews velocity and amplitude toward their targets and holds
// the result item for the sink. Depends on mcsl_pkg and mcsl_channels.
`default_nettype none

module mcsl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mcsl_pkg::entry_t  head,
    input  mcsl_pkg::q_stat_t stat,
    output logic              pop,
    mcsl_result_if.source     result
);
    import mcsl_pkg::*;

    // Move now toward tgt by at most the rising or the falling step.
    function automatic logic [VEL_W-1:0] step_toward(
        input logic [VEL_W-1:0] now,
        input logic [VEL_W-1:0] tgt,
        input step_t            rise,
        input step_t            fall
    );
        step_t gap;
        if (tgt > now)
        begin
            gap = STEP_W'(tgt - now);
            return (gap > rise) ? now + VEL_W'(rise) : tgt;
        end
        else if (tgt < now)
        begin
            gap = STEP_W'(now - tgt);
            return (gap > fall) ? now - VEL_W'(fall) : tgt;
        end
        return now;
    endfunction

    logic [VEL_W-1:0]          vel_now_reg;
    logic [AMP_W-1:0]          amp_now_reg;
    logic [VEL_W-1:0]          vel_next;
    logic [AMP_W-1:0]          amp_next;
    logic                      out_valid_reg;
    logic                      out_init_reg;
    logic [VEL_W-1:0]          out_vel_reg;
    logic [AMP_W-1:0]          out_amp_reg;
    logic signed [PHASE_W-1:0] out_phase_reg;

    // Take the head item whenever the output register is free or draining.
    assign pop = !stat.empty && (!out_valid_reg || result.ready);

    assign vel_next = step_toward(vel_now_reg, head.vel_target,
                                  head.vel_rise_step, head.vel_fall_step);
    assign amp_next = AMP_W'(step_toward(VEL_W'(amp_now_reg), VEL_W'(head.amp_target),
                                         head.amp_rise_step, head.amp_fall_step));

    // Slew state and output valid; an init item leaves the state alone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_now_reg   <= '0;
            amp_now_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                if (!head.is_init)
                begin
                    vel_now_reg <= vel_next;
                    amp_now_reg <= amp_next;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_init_reg  <= head.is_init;
            out_vel_reg   <= head.is_init ? '0 : vel_next;
            out_amp_reg   <= head.is_init ? '0 : amp_next;
            out_phase_reg <= head.phase;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.is_init       = out_init_reg;
    assign result.velocity_cmd  = out_vel_reg;
    assign result.amplitude_cmd = out_amp_reg;
    assign result.phase_cmd     = out_phase_reg;

endmodule

`default_nettype wire

[src/motor_command_slew_limiter.sv]
// Motor command slew limiter: tick item in, one result item out per tick.
// A result passes, in order, the first classify stage (loaded at the accepting
// edge), the second classify stage, the queue write and the output register;
// throughput one item per cycle while the sink takes results and the queue has
// credit, set by the combinational slew compare in the back part.
// Reset clears the slew state and the first-tick flag and loads the default
// registers at once; no clearing pass. Depends on mcsl_pkg and all src parts.
`default_nettype none

module motor_command_slew_limiter #(
    parameter int unsigned DT_MAX_US = mcsl_pkg::DT_MAX_US_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    mcsl_tick_if.sink     tick,
    mcsl_result_if.source result,
    mcsl_cfg_if.sink      cfg
);
    import mcsl_pkg::*;

    cfg_t    regs;
    q_wr_t   q_wr;
    entry_t  q_head;
    q_stat_t q_stat;
    logic    pop;

    // Register bank.
    mcsl_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Accept and classify.
    mcsl_front #(
        .DT_MAX_US (DT_MAX_US)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .regs  (regs),
        .pop   (pop),
        .wr    (q_wr)
    );

    // Decoupling queue.
    mcsl_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .pop   (pop),
        .head  (q_head),
        .stat  (q_stat)
    );

    // Slew and output.
    mcsl_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .stat   (q_stat),
        .pop    (pop),
        .result (result)
    );

    // The credit scheme must never push into a full queue unless it drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push && q_stat.full |-> pop)
    else $error("item pushed into a full queue");

    // The back part only takes items that are there.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
    else $error("item taken from an empty queue");

    // An init result carries no commands.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.is_init |->
            result.velocity_cmd == '0 && result.amplitude_cmd == '0 &&
            result.phase_cmd == '0)
    else $error("init result with non-zero commands");

endmodule

`default_nettype wire

[bench/mcsl_command_checker.sv]
// Command checker for the motor command slew limiter: watches the tick, result
// and register channels, predicts each result item and compares it field by field.
// Depends on mcsl_pkg and the channel interfaces in mcsl_channels.
`default_nettype none

module mcsl_command_checker #(
    parameter int unsigned DT_LIMIT_US = mcsl_pkg::DT_MAX_US_DEFAULT
) (
    input  logic   clk,
    input  logic   rst_n,
    mcsl_tick_if   tick,
    mcsl_result_if result,
    mcsl_cfg_if    cfg,
    output int     failures,
    output int     pending,
    output int     checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import mcsl_pkg::*;

    localparam longint unsigned PULSE_SPAN = PULSE_HI - PULSE_LO;

    // One predicted result item.
    typedef struct packed {
        logic               is_init;
        logic [VEL_W-1:0]   velocity;
        logic [AMP_W-1:0]   amplitude;
        logic [PHASE_W-1:0] phase;
    } command_t;

    command_t commands_due[$];

    // Register copy.
    logic [VEL_W-1:0]  velocity_max;
    logic [AMP_W-1:0]  amplitude_max;
    logic [LIM_W-1:0]  phase_limit;
    logic [RATE_W-1:0] velocity_rise;
    logic [RATE_W-1:0] velocity_fall;
    logic [RATE_W-1:0] amplitude_rise;
    logic [RATE_W-1:0] amplitude_fall;

    // Slew state.
    logic [VEL_W-1:0]  velocity_now;
    logic [AMP_W-1:0]  amplitude_now;
    logic [TIME_W-1:0] last_stamp;
    logic              first_seen;

    // Clamp a pulse width into the window and return its offset, 0..1000.
    function automatic longint unsigned pulse_offset(input logic [PULSE_W-1:0] pulse);
        longint unsigned p;
        p = pulse;
        if (p < PULSE_LO)
        begin
            return 0;
        end
        if (p > PULSE_HI)
        begin
            return PULSE_SPAN;
        end
        return p - PULSE_LO;
    endfunction

    // Move toward the target by at most the rise or fall step.
    function automatic longint unsigned slew(input longint unsigned now, input longint unsigned target,
                                             input longint unsigned rise, input longint unsigned fall,
                                             input longint unsigned dt);
        if (target > now)
        begin
            return (target - now > rise * dt) ? now + rise * dt : target;
        end
        if (target < now)
        begin
            return (now - target > fall * dt) ? now - fall * dt : target;
        end
        return now;
    endfunction

    // Work out the commands for one tick and advance the slew state.
    function automatic command_t predict_commands(input logic [TIME_W-1:0] stamp, input logic arm,
                                                  input logic [PULSE_W-1:0] throttle,
                                                  input logic [PULSE_W-1:0] aux1,
                                                  input logic [PULSE_W-1:0] aux2);
        command_t          cmd;
        logic [TIME_W-1:0] diff;
        longint unsigned   dt;
        longint unsigned   lim;
        longint unsigned   velocity_goal;
        longint unsigned   amplitude_goal;
        longint unsigned   phase_wide;
        cmd = '0;
        if (!first_seen)
        begin
            first_seen = 1'b1;
            last_stamp = stamp;
            cmd.is_init = 1'b1;
            return cmd;
        end

        // A backward step holds the commands; a long gap saturates.
        diff = stamp - last_stamp;
        last_stamp = stamp;
        if (diff[TIME_W-1])
        begin
            dt = 0;
        end
        else
        begin
            dt = (diff > DT_LIMIT_US) ? DT_LIMIT_US : diff;
        end

        velocity_goal = 0;
        amplitude_goal = 0;
        phase_wide = 0;
        if (arm)
        begin
            lim = phase_limit;
            velocity_goal = velocity_max * pulse_offset(throttle) / PULSE_SPAN;
            amplitude_goal = amplitude_max * pulse_offset(aux1) / PULSE_SPAN;
            phase_wide = 2 * lim * pulse_offset(aux2) / PULSE_SPAN - lim;
        end

        velocity_now = VEL_W'(slew(velocity_now, velocity_goal, velocity_rise, velocity_fall, dt));
        amplitude_now = AMP_W'(slew(amplitude_now, amplitude_goal, amplitude_rise,
                                    amplitude_fall, dt));
        cmd.velocity = velocity_now;
        cmd.amplitude = amplitude_now;
        cmd.phase = phase_wide[PHASE_W-1:0];
        return cmd;
    endfunction

    // Results are compared before new ticks are queued, so an item never meets itself.
    always @(posedge clk or negedge rst_n)
    begin
        command_t due;
        if (!rst_n)
        begin
            velocity_max = VEL_MAX_RESET;
            amplitude_max = AMP_MAX_RESET;
            phase_limit = LIM_RESET;
            velocity_rise = VEL_RISE_RESET;
            velocity_fall = VEL_FALL_RESET;
            amplitude_rise = AMP_RISE_RESET;
            amplitude_fall = AMP_FALL_RESET;
            velocity_now = '0;
            amplitude_now = '0;
            last_stamp = '0;
            first_seen = 1'b0;
            commands_due.delete();
            failures = 0;
            checked = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (commands_due.size() == 0)
                begin
                    failures++;
                    $display("%0t: result item arrived with no tick waiting", $time);
                end
                else
                begin
                    due = commands_due.pop_front();
                    checked++;
                    if (result.is_init !== due.is_init)
                    begin
                        failures++;
                        $display("%0t: is_init expected %0d, got %0d",
                                 $time, due.is_init, result.is_init);
                    end
                    if (result.velocity_cmd !== due.velocity)
                    begin
                        failures++;
                        $display("%0t: velocity_cmd expected %0d, got %0d",
                                 $time, due.velocity, result.velocity_cmd);
                    end
                    if (result.amplitude_cmd !== due.amplitude)
                    begin
                        failures++;
                        $display("%0t: amplitude_cmd expected %0d, got %0d",
                                 $time, due.amplitude, result.amplitude_cmd);
                    end
                    if (result.phase_cmd !== due.phase)
                    begin
                        failures++;
                        $display("%0t: phase_cmd expected %0d, got %0d",
                                 $time, $signed(due.phase), result.phase_cmd);
                    end
                end
            end

            // Register writes; an index beyond the list is ignored.
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    CFG_VELOCITY_MAX:        velocity_max = cfg.data[VEL_W-1:0];
                    CFG_AMPLITUDE_MAX:       amplitude_max = cfg.data[AMP_W-1:0];
                    CFG_PHASE_LIMIT:         phase_limit = cfg.data[LIM_W-1:0];
                    CFG_VELOCITY_RISE_RATE:  velocity_rise = cfg.data[RATE_W-1:0];
                    CFG_VELOCITY_FALL_RATE:  velocity_fall = cfg.data[RATE_W-1:0];
                    CFG_AMPLITUDE_RISE_RATE: amplitude_rise = cfg.data[RATE_W-1:0];
                    CFG_AMPLITUDE_FALL_RATE: amplitude_fall = cfg.data[RATE_W-1:0];
                    default: ;
                endcase
            end

            if (tick.valid && tick.ready)
            begin
                commands_due.push_back(predict_commands(tick.time_us, tick.armed,
                                                        tick.throttle_pulse, tick.aux1_pulse,
                                                        tick.aux2_pulse));
            end
        end
        pending = commands_due.size();
    end

endmodule

`default_nettype wire

[bench/testbench.sv]
// Top of the slew limiter bench: clock, reset, tick and register stimulus, result
// back-pressure, watchdog and verdict. Depends on mcsl_pkg, mcsl_channels,
// motor_command_slew_limiter and mcsl_command_checker.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcsl_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int PHASE_TICKS    = 290;
    localparam int PRESSURE_AT    = 450;
    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;

    // Index past the register list; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    typedef enum {SET_DEFAULT, SET_TOP, SET_ZERO, SET_ONES, SET_RANDOM} setting_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int                ticks_sent = 0;
    int                phases_run = 0;
    int                idle_cycles = 0;
    bit                full_rate = 1'b0;
    bit                stall_done = 1'b0;
    logic [TIME_W-1:0] clock_us;
    setting_t          plan [6];

    int failures;
    int pending;
    int checked;

    mcsl_tick_if   tick_ch ();
    mcsl_result_if result_ch ();
    mcsl_cfg_if    cfg_ch ();

    motor_command_slew_limiter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    mcsl_command_checker command_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick_ch),
        .result   (result_ch),
        .cfg      (cfg_ch),
        .failures (failures),
        .pending  (pending),
        .checked  (checked)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 40);
    endfunction

    // Pulses mostly near the window, some anywhere in the field.
    function automatic logic [PULSE_W-1:0] pulse_pick();
        if ($urandom_range(0, 99) < 80)
        begin
            return PULSE_W'($urandom_range(950, 2050));
        end
        return PULSE_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] setting_for(input setting_t mode,
                                                          input cfg_reg_t which);
        case (mode)
            SET_ZERO: return '0;
            SET_ONES: return '1;
            SET_DEFAULT:
                case (which)
                    CFG_VELOCITY_MAX:        return CFG_DATA_W'(VEL_MAX_RESET);
                    CFG_AMPLITUDE_MAX:       return CFG_DATA_W'(AMP_MAX_RESET);
                    CFG_PHASE_LIMIT:         return CFG_DATA_W'(LIM_RESET);
                    CFG_VELOCITY_RISE_RATE:  return CFG_DATA_W'(VEL_RISE_RESET);
                    CFG_VELOCITY_FALL_RATE:  return CFG_DATA_W'(VEL_FALL_RESET);
                    CFG_AMPLITUDE_RISE_RATE: return CFG_DATA_W'(AMP_RISE_RESET);
                    default:                 return CFG_DATA_W'(AMP_FALL_RESET);
                endcase
            SET_TOP:
                case (which)
                    CFG_VELOCITY_MAX:  return 30'd1000000000;
                    CFG_AMPLITUDE_MAX: return 30'd100000000;
                    CFG_PHASE_LIMIT:   return 30'd4000000;
                    default:           return 30'd100000;
                endcase
            default:
                case (which)
                    CFG_VELOCITY_MAX:  return CFG_DATA_W'($urandom_range(0, 1000000000));
                    CFG_AMPLITUDE_MAX: return CFG_DATA_W'($urandom_range(0, 100000000));
                    CFG_PHASE_LIMIT:   return CFG_DATA_W'($urandom_range(0, 4000000));
                    default:
                        // Slow rates mostly, so that the slewing stays visible.
                        return CFG_DATA_W'(($urandom_range(0, 3) != 0)
                                           ? $urandom_range(0, 3000)
                                           : $urandom_range(0, 100000));
                endcase
        endcase
    endfunction

    // Advance the microsecond clock and offer one tick item until it is taken.
    task automatic send_tick(input logic [TIME_W-1:0] delta, input logic arm,
                             input logic [PULSE_W-1:0] throttle,
                             input logic [PULSE_W-1:0] aux1, input logic [PULSE_W-1:0] aux2);
        bit took;
        int gap;
        clock_us = clock_us + delta;
        tick_ch.valid <= 1'b1;
        tick_ch.time_us <= clock_us;
        tick_ch.armed <= arm;
        tick_ch.throttle_pulse <= throttle;
        tick_ch.aux1_pulse <= aux1;
        tick_ch.aux2_pulse <= aux2;
        do
        begin
            @(negedge clk);
            took = tick_ch.ready;
            @(posedge clk);
        end
        while (!took);
        ticks_sent++;
        gap = full_rate ? 0 : idle_length();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        bit took;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= value;
        do
        begin
            @(negedge clk);
            took = cfg_ch.ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // Write every register, then the unused index with random data.
    task automatic apply_setting(input setting_t mode);
        cfg_reg_t which;
        which = which.first();
        do
        begin
            write_reg(which, setting_for(mode, which));
            which = which.next();
        end
        while (which != which.first());
        write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom()));
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering ticks and wait until every result item has come back.
    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
    endtask

    // Result back-pressure: random runs, one long hold-off, none in full-rate phases.
    initial
    begin
        int  run;
        bit  level;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!stall_done && ticks_sent >= PRESSURE_AT)
            begin
                stall_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            else if (full_rate)
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                level = ($urandom_range(0, 99) < 70);
                run = level ? $urandom_range(1, 12) : idle_length() + 1;
                result_ch.ready <= level;
                repeat (run) @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(negedge clk)
    begin
        if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        logic [PULSE_W-1:0] throttle;
        logic [PULSE_W-1:0] aux1;
        logic [PULSE_W-1:0] aux2;
        logic [TIME_W-1:0]  delta;
        logic               arm;
        int                 pick;
        plan = '{SET_TOP, SET_RANDOM, SET_ZERO, SET_ONES, SET_DEFAULT, SET_RANDOM};
        tick_ch.valid <= 1'b0;
        tick_ch.time_us <= '0;
        tick_ch.armed <= 1'b0;
        tick_ch.throttle_pulse <= '0;
        tick_ch.aux1_pulse <= '0;
        tick_ch.aux2_pulse <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset registers. The first tick only records
        // time, just below the wrap so that the next step crosses it.
        clock_us = 32'hFFFF_FF00;
        send_tick(0, 1'b1, 12'd2000, 12'd2000, 12'd2000);
        send_tick(10000, 1'b1, 12'd2000, 12'd2000, 12'd2000);
        send_tick(10000, 1'b1, 12'd4095, 12'd4095, 12'd4095);
        send_tick(3000, 1'b1, 12'd0, 12'd0, 12'd0);
        send_tick(10000, 1'b1, 12'd1000, 12'd1000, 12'd1000);
        send_tick(1, 1'b1, 12'd2000, 12'd1500, 12'd1999);
        send_tick(0, 1'b1, 12'd2001, 12'd999, 12'd1001);
        // Time going backwards holds the commands.
        send_tick(32'hFFFF_FC18, 1'b1, 12'd2000, 12'd2000, 12'd2000);
        // Largest forward step saturates; half the range counts as backwards.
        send_tick(32'h7FFF_FFFF, 1'b1, 12'd2000, 12'd2000, 12'd2000);
        send_tick(32'h8000_0000, 1'b1, 12'd1500, 12'd1500, 12'd1500);
        send_tick(10001, 1'b1, 12'd1500, 12'd1500, 12'd1500);
        // Disarmed: all targets zero whatever the pulses say.
        send_tick(9999, 1'b0, 12'd2000, 12'd2000, 12'd2000);
        send_tick(10000, 1'b0, 12'd4095, 12'd0, 12'd4095);
        send_tick(10000, 1'b1, 12'd1500, 12'd500, 12'd2000);
        send_tick(10000, 1'b1, 12'hAAA, 12'h555, 12'hFFF);
        send_tick(10000, 1'b1, 12'h555, 12'hAAA, 12'h000);

        // Random part, one register setting per phase.
        for (int p = 0; p < $size(plan); p++)
        begin
            wait_idle();
            @(posedge clk);
            apply_setting(plan[p]);
            full_rate = (plan[p] == SET_DEFAULT);
            phases_run++;
            throttle = 12'd1500;
            aux1 = 12'd1500;
            aux2 = 12'd1500;
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    delta = $urandom_range(0, 12000);
                end
                else if (pick < 80)
                begin
                    delta = $urandom_range(0, 200);
                end
                else if (pick < 88)
                begin
                    delta = $urandom();
                end
                else if (pick < 95)
                begin
                    delta = 32'hFFFF_FFFF - $urandom_range(0, 99999);
                end
                else
                begin
                    delta = DT_MAX_US_DEFAULT;
                end
                // Sticks are often held so the commands settle on their targets.
                if ($urandom_range(0, 1) != 0)
                begin
                    throttle = pulse_pick();
                    aux1 = pulse_pick();
                    aux2 = pulse_pick();
                end
                arm = ($urandom_range(0, 99) < 85);
                send_tick(delta, arm, throttle, aux1, aux2);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Covered %0d ticks under %0d register settings, with wrapped, backward",
                 ticks_sent, phases_run + 1);
        $display("and saturated time steps; %0d result items compared, %0d failures.",
                 checked, failures);
        if (failures == 0 && pending == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
